/* rtl/core/skt_pkg.sv */
package skt_pkg;

    localparam int KEY_W     = 64;
    localparam int TIER_W    = 4;
    localparam int BUDGET_W  = 32;
    localparam int ACT_W     = 3;
    localparam int IDX_W     = 8;
    localparam int CAP_W     = 5;
    localparam int CNT_OUT_W = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SET_EN     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SET_TIER   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SET_BUDGET = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ       = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_TIER = 1'b1;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [TIER_W-1:0] TIER_RESET = 4'd0;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_NO_STORAGE = 3'd1,
        STS_FULL       = 3'd2,
        STS_DUPLICATE  = 3'd3,
        STS_NOT_FOUND  = 3'd4,
        STS_RANGE      = 3'd5
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic                enabled;
        logic [TIER_W-1:0]   tier;
        logic [BUDGET_W-1:0] budget;
    } t_cell_data;

    typedef struct packed {
        logic                insert;
        logic                set_en;
        logic                set_tier;
        logic                set_budget;
        logic [KEY_W-1:0]    new_key;
        logic [TIER_W-1:0]   new_tier;
        logic                en_value;
        logic [TIER_W-1:0]   tier_value;
        logic [BUDGET_W-1:0] budget_value;
    } t_cell_cmd;

endpackage

/* rtl/core/sorted_key_table.sv */
// Sorted key table: up to TABLE_DEPTH entries held in ascending key order in a
// row of cells, one entry per cell. On acceptance of a word, every cell
// compares its key with the word's key at once and registers the result;
// then the action commits (an insert shifts the larger entries up one cell)
// and the result goes into the output register. The next word is accepted
// once that commit is done, even while the result still waits to be taken;
// the commit itself waits while the output register is full.
module sorted_key_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [skt_pkg::ACT_W-1:0]      i_action,
    input  logic [skt_pkg::KEY_W-1:0]      i_key,
    input  logic                           i_enabled_value,
    input  logic [skt_pkg::TIER_W-1:0]     i_tier_value,
    input  logic [skt_pkg::BUDGET_W-1:0]   i_budget_value,
    input  logic [skt_pkg::IDX_W-1:0]      i_slot_index,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [2:0]                     o_status,
    output logic [skt_pkg::KEY_W-1:0]      o_key_out,
    output logic [skt_pkg::CNT_OUT_W-1:0]  o_entry_count,
    input  logic                           i_cfg_we,
    input  logic [skt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [skt_pkg::CAP_W-1:0]      i_cfg_data
);
    import skt_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [8:0] DEPTH9 = 9'(TABLE_DEPTH);

    t_state                r_state;
    t_state                n_state;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [CAP_W-1:0]      r_cap;
    logic [TIER_W-1:0]     r_def_tier;

    logic [ACT_W-1:0]      r_action;
    logic [KEY_W-1:0]      r_key;
    logic                  r_en;
    logic [TIER_W-1:0]     r_tier;
    logic [BUDGET_W-1:0]   r_budget;
    logic [IDX_W-1:0]      r_idx;

    logic                  r_out_valid;
    t_status               r_status;
    logic [KEY_W-1:0]      r_key_out;
    logic [CNT_OUT_W-1:0]  r_count_out;

    logic                  accept;
    logic                  apply_go;
    t_status               status;
    logic [KEY_W-1:0]      key_rd;
    logic [KEY_W-1:0]      key_or;
    logic                  any_eq;
    logic                  in_range;
    logic [8:0]            cap_eff;
    t_cell_cmd             cmd;

    t_cell_data            c_data [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] lt_vec;
    logic [TABLE_DEPTH-1:0] eq_vec;
    logic [TABLE_DEPTH-1:0] sel_vec;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        apply_go   = 1'b0;
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_APPLY: apply_go   = !r_out_valid || i_out_ready;
            default: begin
                o_in_ready = 1'b0;
                apply_go   = 1'b0;
            end
        endcase
    end

    assign accept = i_in_valid && o_in_ready;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            localparam logic [8:0] POS = 9'(g);
            t_cell_data prev_data;
            logic       prev_lt;
            if (g == 0) begin : g_head
                assign prev_data = '0;
                assign prev_lt   = 1'b1;
            end else begin : g_link
                assign prev_data = c_data[g-1];
                assign prev_lt   = lt_vec[g-1];
            end
            skt_cell u_cell (
                .i_clk     (i_clk),
                .i_capture (accept),
                .i_key     (i_key),
                .i_valid   (9'(r_count) > POS),
                .i_sel     ({1'b0, i_slot_index} == POS),
                .i_cmd     (cmd),
                .i_prev    (prev_data),
                .i_prev_lt (prev_lt),
                .o_data    (c_data[g]),
                .o_lt      (lt_vec[g]),
                .o_eq      (eq_vec[g]),
                .o_sel     (sel_vec[g])
            );
        end
    endgenerate

    always_comb begin
        key_or = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            key_or = key_or | (sel_vec[k] ? c_data[k].key : '0);
        end
    end

    assign any_eq   = |eq_vec;
    assign in_range = {1'b0, r_idx} < 9'(r_count);
    assign cap_eff  = (9'(r_cap) < DEPTH9) ? 9'(r_cap) : DEPTH9;

    always_comb begin
        status = STS_OK;
        key_rd = '0;
        case (r_action)
            ACT_INSERT: begin
                if (r_cap == '0) begin
                    status = STS_NO_STORAGE;
                end else if (9'(r_count) >= cap_eff) begin
                    status = STS_FULL;
                end else if (any_eq) begin
                    status = STS_DUPLICATE;
                end
            end
            ACT_SET_EN, ACT_SET_TIER, ACT_SET_BUDGET: begin
                if (!any_eq) begin
                    status = STS_NOT_FOUND;
                end
            end
            ACT_READ: begin
                if (in_range) begin
                    key_rd = key_or;
                end else begin
                    status = STS_RANGE;
                end
            end
            default: status = STS_OK;
        endcase
    end

    always_comb begin
        cmd              = '0;
        cmd.insert       = apply_go && (r_action == ACT_INSERT) && (status == STS_OK);
        cmd.set_en       = apply_go && (r_action == ACT_SET_EN);
        cmd.set_tier     = apply_go && (r_action == ACT_SET_TIER);
        cmd.set_budget   = apply_go && (r_action == ACT_SET_BUDGET);
        cmd.new_key      = r_key;
        cmd.new_tier     = r_def_tier;
        cmd.en_value     = r_en;
        cmd.tier_value   = r_tier;
        cmd.budget_value = r_budget;
    end

    always_comb begin
        n_count = r_count;
        if (apply_go && (r_action == ACT_CLEAR)) begin
            n_count = '0;
        end else if (cmd.insert) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_cap       <= CAP_RESET;
            r_def_tier  <= TIER_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (apply_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CAPACITY: r_cap      <= i_cfg_data;
                    CFG_DEF_TIER: r_def_tier <= i_cfg_data[TIER_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_key    <= i_key;
            r_en     <= i_enabled_value;
            r_tier   <= i_tier_value;
            r_budget <= i_budget_value;
            r_idx    <= i_slot_index;
        end
        if (apply_go) begin
            r_status    <= status;
            r_key_out   <= key_rd;
            r_count_out <= CNT_OUT_W'(n_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_key_out     = r_key_out;
    assign o_entry_count = r_count_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        9'(r_count) <= DEPTH9)
        else $error("entry count above table depth");

    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> $onehot0(eq_vec))
        else $error("more than one cell matches the key");

    a_lt_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> ((lt_vec & (lt_vec + 1'b1)) == '0))
        else $error("table order broken");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.insert |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not add an entry");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_APPLY))
        else $error("result word without a commit");
`endif

endmodule

/* rtl/core/skt_cell.sv */
module skt_cell (
    input  logic                     i_clk,
    input  logic                     i_capture,
    input  logic [skt_pkg::KEY_W-1:0] i_key,
    input  logic                     i_valid,
    input  logic                     i_sel,
    input  skt_pkg::t_cell_cmd       i_cmd,
    input  skt_pkg::t_cell_data      i_prev,
    input  logic                     i_prev_lt,
    output skt_pkg::t_cell_data      o_data,
    output logic                     o_lt,
    output logic                     o_eq,
    output logic                     o_sel
);
    import skt_pkg::*;

    t_cell_data r_data;
    t_cell_data n_data;
    logic       r_lt;
    logic       r_eq;
    logic       r_sel;

    always_comb begin
        n_data = r_data;
        if (i_cmd.insert && !r_lt) begin
            if (i_prev_lt) begin
                n_data.key     = i_cmd.new_key;
                n_data.enabled = 1'b1;
                n_data.tier    = i_cmd.new_tier;
                n_data.budget  = '0;
            end else begin
                n_data = i_prev;
            end
        end
        if (r_eq) begin
            if (i_cmd.set_en) begin
                n_data.enabled = i_cmd.en_value;
            end
            if (i_cmd.set_tier) begin
                n_data.tier = i_cmd.tier_value;
            end
            if (i_cmd.set_budget) begin
                n_data.budget = i_cmd.budget_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_capture) begin
            r_lt  <= i_valid && (r_data.key < i_key);
            r_eq  <= i_valid && (r_data.key == i_key);
            r_sel <= i_sel;
        end
    end

    assign o_data = r_data;
    assign o_lt   = r_lt;
    assign o_eq   = r_eq;
    assign o_sel  = r_sel;

endmodule

/* tb/sorted_key_table_test.sv */
module sorted_key_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import skt_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX = 10;
    localparam int POOL_SIZE = 24;

    typedef struct {
        logic [ACT_W-1:0]    action;
        logic [KEY_W-1:0]    key;
        logic                en;
        logic [TIER_W-1:0]   tier;
        logic [BUDGET_W-1:0] budget;
        logic [IDX_W-1:0]    idx;
    } t_word_in;

    typedef struct {
        t_status              status;
        logic [KEY_W-1:0]     key;
        logic [CNT_OUT_W-1:0] count;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [ACT_W-1:0]      i_action = '0;
    logic [KEY_W-1:0]      i_key = '0;
    logic                  i_enabled_value = 1'b0;
    logic [TIER_W-1:0]     i_tier_value = '0;
    logic [BUDGET_W-1:0]   i_budget_value = '0;
    logic [IDX_W-1:0]      i_slot_index = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [2:0]            o_status;
    logic [KEY_W-1:0]      o_key_out;
    logic [CNT_OUT_W-1:0]  o_entry_count;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CAP_W-1:0]      i_cfg_data = '0;

    sorted_key_table #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_key          (i_key),
        .i_enabled_value(i_enabled_value),
        .i_tier_value   (i_tier_value),
        .i_budget_value (i_budget_value),
        .i_slot_index   (i_slot_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_key_out      (o_key_out),
        .o_entry_count  (o_entry_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // table shadow
    logic [KEY_W-1:0]    tbl_key    [DEPTH];
    logic                tbl_enabled[DEPTH];
    logic [TIER_W-1:0]   tbl_tier   [DEPTH];
    logic [BUDGET_W-1:0] tbl_budget [DEPTH];
    int                  live_count = 0;
    int                  cap_in_use = int'(CAP_RESET);
    logic [TIER_W-1:0]   def_tier = TIER_RESET;

    t_word_in   pending_words[$];
    t_result    expected_results[$];
    t_word_in   cur_word;
    int         words_in_flight = 0;
    int         mismatch_count = 0;
    int         cycle_count = 0;
    bit         calm = 1'b0;
    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    function automatic int find_key(logic [KEY_W-1:0] key);
        for (int i = 0; i < live_count; i++) begin
            if (tbl_key[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic t_result predict_result(t_word_in w);
        t_result r;
        int pos;
        int usable;
        int at;
        r.status = STS_OK;
        r.key = '0;
        case (w.action)
            ACT_CLEAR: begin
                live_count = 0;
            end
            ACT_INSERT: begin
                usable = (cap_in_use > DEPTH) ? DEPTH : cap_in_use;
                pos = find_key(w.key);
                if (usable == 0) begin
                    r.status = STS_NO_STORAGE;
                end else if (live_count >= usable) begin
                    r.status = STS_FULL;
                end else if (pos >= 0) begin
                    r.status = STS_DUPLICATE;
                end else begin
                    at = 0;
                    while (at < live_count && tbl_key[at] < w.key) at++;
                    for (int i = live_count; i > at; i--) begin
                        tbl_key[i]     = tbl_key[i-1];
                        tbl_enabled[i] = tbl_enabled[i-1];
                        tbl_tier[i]    = tbl_tier[i-1];
                        tbl_budget[i]  = tbl_budget[i-1];
                    end
                    tbl_key[at]     = w.key;
                    tbl_enabled[at] = 1'b1;
                    tbl_tier[at]    = def_tier;
                    tbl_budget[at]  = '0;
                    live_count++;
                end
            end
            ACT_SET_EN, ACT_SET_TIER, ACT_SET_BUDGET: begin
                pos = find_key(w.key);
                if (pos < 0) begin
                    r.status = STS_NOT_FOUND;
                end else if (w.action == ACT_SET_EN) begin
                    tbl_enabled[pos] = w.en;
                end else if (w.action == ACT_SET_TIER) begin
                    tbl_tier[pos] = w.tier;
                end else begin
                    tbl_budget[pos] = w.budget;
                end
            end
            ACT_READ: begin
                if (int'(w.idx) < live_count) begin
                    r.key = tbl_key[w.idx];
                end else begin
                    r.status = STS_RANGE;
                end
            end
            default: begin
            end
        endcase
        r.count = CNT_OUT_W'(live_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [KEY_W-1:0] exp_v, logic [KEY_W-1:0] got_v);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch %s: expected %h, got %h", what, exp_v, got_v);
        end
    endtask

    // sender
    always @(posedge i_clk) begin : drive_words
        logic send;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(predict_result(cur_word));
            end
            if (!i_in_valid || o_in_ready) begin
                send = (pending_words.size() != 0) && (calm || $urandom_range(99) >= 7);
                if (send) begin
                    cur_word = pending_words.pop_front();
                    i_action        <= cur_word.action;
                    i_key           <= cur_word.key;
                    i_enabled_value <= cur_word.en;
                    i_tier_value    <= cur_word.tier;
                    i_budget_value  <= cur_word.budget;
                    i_slot_index    <= cur_word.idx;
                end
                i_in_valid <= send;
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin : check_results
        t_result exp_r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word, status", '0, KEY_W'(o_status));
                end else begin
                    exp_r = expected_results.pop_front();
                    words_in_flight--;
                    if (o_status !== exp_r.status)
                        report_mismatch("status", KEY_W'(exp_r.status), KEY_W'(o_status));
                    if (o_key_out !== exp_r.key)
                        report_mismatch("key_out", exp_r.key, o_key_out);
                    if (o_entry_count !== exp_r.count)
                        report_mismatch("entry_count", KEY_W'(exp_r.count), KEY_W'(o_entry_count));
                end
            end
            i_out_ready <= calm || $urandom_range(99) >= 7;
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic queue_word(logic [ACT_W-1:0] action, logic [KEY_W-1:0] key,
                              logic en, logic [TIER_W-1:0] tier,
                              logic [BUDGET_W-1:0] budget, logic [IDX_W-1:0] idx);
        t_word_in w;
        w.action = action;
        w.key    = key;
        w.en     = en;
        w.tier   = tier;
        w.budget = budget;
        w.idx    = idx;
        pending_words.push_back(w);
        words_in_flight++;
    endtask

    task automatic wait_drained();
        while (words_in_flight != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CAPACITY) cap_in_use = int'(data);
        else def_tier = data[TIER_W-1:0];
    endtask

    task automatic queue_random_word();
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;
        int r;
        r = $urandom_range(99);
        if (r < 38)      action = ACT_INSERT;
        else if (r < 50) action = ACT_SET_EN;
        else if (r < 60) action = ACT_SET_TIER;
        else if (r < 70) action = ACT_SET_BUDGET;
        else if (r < 96) action = ACT_READ;
        else if (r < 98) action = ACT_CLEAR;
        else             action = ACT_W'($urandom_range(6, 7));
        if ($urandom_range(9) == 0) key = {$urandom, $urandom};
        else key = key_pool[$urandom_range(POOL_SIZE - 1)];
        if ($urandom_range(99) < 85) idx = IDX_W'($urandom_range(17));
        else idx = IDX_W'($urandom_range(255));
        queue_word(action, key, 1'($urandom), TIER_W'($urandom), $urandom, idx);
    endtask

    initial begin : stimulus
        int phase_cap[8];
        int phase_tier[8];
        int phase_len[8];
        logic [KEY_W-1:0] ones;
        logic [KEY_W-1:0] mid;
        ones = '1;
        mid = {1'b1, {(KEY_W-1){1'b0}}};
        phase_cap  = '{16, 31, 4, 0, 1, 16, 12, 17};
        phase_tier = '{0, 15, 9, 3, 7, 5, 15, 0};
        phase_len  = '{240, 240, 150, 50, 120, 300, 200, 150};
        for (int i = 0; i < DEPTH; i++) begin
            tbl_key[i] = '0;
            tbl_enabled[i] = 1'b0;
            tbl_tier[i] = '0;
            tbl_budget[i] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, then basic ordering, keyed updates, unknown actions and clear
        queue_word(ACT_READ, '0, 1'b0, '0, '0, 8'd0);
        queue_word(ACT_SET_EN, 64'd5, 1'b1, '0, '0, '0);
        queue_word(ACT_SET_TIER, 64'd5, 1'b0, 4'hf, '0, '0);
        queue_word(ACT_SET_BUDGET, 64'd5, 1'b0, '0, '1, '0);
        queue_word(ACT_INSERT, ones, 1'b0, '0, '0, '0);
        queue_word(ACT_INSERT, '0, 1'b0, '0, '0, '0);
        queue_word(ACT_INSERT, mid, 1'b0, '0, '0, '0);
        queue_word(ACT_INSERT, '0, 1'b1, 4'hf, '1, '1);
        queue_word(ACT_READ, '0, 1'b0, '0, '0, 8'd0);
        queue_word(ACT_READ, '0, 1'b0, '0, '0, 8'd1);
        queue_word(ACT_READ, '0, 1'b0, '0, '0, 8'd2);
        queue_word(ACT_READ, '0, 1'b0, '0, '0, 8'd3);
        queue_word(ACT_READ, ones, 1'b1, 4'hf, '1, 8'd255);
        queue_word(ACT_SET_EN, '0, 1'b0, '0, '0, '0);
        queue_word(ACT_SET_TIER, ones, 1'b0, 4'hf, '0, '0);
        queue_word(ACT_SET_BUDGET, mid, 1'b0, '0, '1, '0);
        queue_word(3'd6, ones, 1'b1, 4'hf, '1, 8'd1);
        queue_word(3'd7, ones, 1'b1, 4'hf, '1, 8'd0);
        queue_word(ACT_CLEAR, ones, 1'b1, 4'hf, '1, '1);
        queue_word(ACT_READ, '0, 1'b0, '0, '0, 8'd0);
        wait_drained();

        // no storage
        write_reg(CFG_CAPACITY, 5'd0);
        queue_word(ACT_INSERT, 64'd9, 1'b0, '0, '0, '0);
        wait_drained();
        // fill a small table, then shrink it below the count
        write_reg(CFG_CAPACITY, 5'd2);
        write_reg(CFG_DEF_TIER, 5'd15);
        queue_word(ACT_INSERT, 64'd20, 1'b0, '0, '0, '0);
        queue_word(ACT_INSERT, 64'd10, 1'b0, '0, '0, '0);
        queue_word(ACT_INSERT, 64'd30, 1'b0, '0, '0, '0);
        wait_drained();
        write_reg(CFG_CAPACITY, 5'd1);
        queue_word(ACT_INSERT, 64'd40, 1'b0, '0, '0, '0);
        queue_word(ACT_READ, '0, 1'b0, '0, '0, 8'd1);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            key_pool[0] = '0;
            key_pool[1] = ones;
            for (int k = 2; k < POOL_SIZE; k++) key_pool[k] = {$urandom, $urandom};
            write_reg(CFG_CAPACITY, CAP_W'(phase_cap[p]));
            write_reg(CFG_DEF_TIER, CAP_W'(phase_tier[p]));
            calm = (p == 5);
            for (int n = 0; n < phase_len[p]; n++) queue_random_word();
            wait_drained();
        end
        calm = 1'b0;

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
